// ===== src/lsat_pkg.sv =====
// ----------------------------------------------------------------------------
// lsat_pkg
// Shared widths, types, reset values and register indexes for the largest
// marked square block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsat_pkg;

    localparam int PIXEL_W   = 8;
    localparam int SIZE_W    = 7;
    localparam int END_W     = 6;
    localparam int FWIDTH_W  = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    typedef logic [PIXEL_W-1:0]  pixel_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [END_W-1:0]    end_pos_t;
    typedef logic [FWIDTH_W-1:0] fwidth_t;

    localparam pixel_t  THRESHOLD_RESET = 8'd50;
    localparam fwidth_t FWIDTH_RESET    = 7'd27;
    localparam size_t   SIZE_MAX        = 7'd127;

    // Register index, taken from paddr[2].
    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_FRAME_WIDTH = 1'b1;

endpackage

`default_nettype wire

// ===== src/lsat_if.sv =====
// ----------------------------------------------------------------------------
// lsat_pixel_if / lsat_result_if
// Valid/ready channels for the pixel stream and the per-frame result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsat_pixel_if;
    import lsat_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;
    logic   last_of_frame;

    modport source (output valid, output pixel, output last_of_frame, input ready);
    modport sink   (input valid, input pixel, input last_of_frame, output ready);
endinterface

interface lsat_result_if;
    import lsat_pkg::*;

    logic     valid;
    logic     ready;
    size_t    square_size;
    end_pos_t end_row;
    end_pos_t end_col;

    modport source (output valid, output square_size, output end_row, output end_col,
                    input ready);
    modport sink   (input valid, input square_size, input end_row, input end_col,
                    output ready);
endinterface

`default_nettype wire

// ===== src/largest_square_above_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// largest_square_above_threshold_unit
// Finds the largest square of above-threshold pixels in a raster-scanned frame.
// ----------------------------------------------------------------------------
// Use: pixels arrive on the pix channel in raster order, one transfer each,
// with last_of_frame set on the final pixel of the frame. A pixel is marked
// when it is strictly greater than the threshold register. When the final
// pixel has been processed, one transfer on the res channel gives the side of
// the largest all-marked square and the row and column of its bottom-right
// pixel; on a tie the later pixel wins, so an empty frame reports size 0 at
// the last pixel. No other pixel produces a result.
// Timing: a pixel is taken into an input register, and from there, once it
// may be processed, the recurrence (three-way minimum plus one) is evaluated
// and the state updated; the last pixel of a frame loads the result register.
// One pixel is taken every cycle; the only limit is the single-entry result
// register, which holds the intake of a further last pixel while a previous
// result waits for the receiver.
// Stalls: while the receiver holds res.ready low, ordinary pixels continue
// to flow until a second end-of-frame pixel, which then waits, blocks them.
// Reset: rst_n clears the pipeline, the frame position and the best-square
// tracking, and loads threshold 50 and frame width 27. The line buffer needs
// no clearing as the first row never reads it. The user must write registers
// over the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_square_above_threshold_unit #(
    parameter int MAX_WIDTH  = lsat_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lsat_pkg::DEF_MAX_HEIGHT
) (
    input  wire                           clk,
    input  wire                           rst_n,
    lsat_pixel_if.sink                    pix,
    lsat_result_if.source                 res,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [lsat_pkg::PADDR_W-1:0]   paddr,
    input  wire [lsat_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsat_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import lsat_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = (CW + 1 > FWIDTH_W) ? CW + 1 : FWIDTH_W;
    localparam int CXW = (CW > END_W) ? CW : END_W;
    localparam int RXW = (RW > END_W) ? RW : END_W;

    // Configuration registers
    pixel_t  threshold_reg;
    fwidth_t frame_width_reg;

    // Input register
    logic    pix_valid_reg;
    pixel_t  pixel_reg;
    logic    last_reg;

    // Frame state
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    size_t         left_reg, diag_reg, up_reg;
    size_t         best_size_reg, best_size_next;
    logic [RW-1:0] best_row_reg, best_row_next;
    logic [CW-1:0] best_col_reg, best_col_next;

    // Line buffer of the previous row's sides
    size_t row_sizes [MAX_WIDTH];

    // Result register
    logic     res_valid_reg;
    size_t    res_size_reg;
    end_pos_t res_row_reg;
    end_pos_t res_col_reg;

    logic          proc;
    logic          marked;
    size_t         up, diag, left, min_lu, min3, size;
    logic [WW-1:0] width_eff, fw_ext, max_w;
    logic          wrap;
    logic [CXW-1:0] col_ext;
    logic [RXW-1:0] row_ext;

    // ------------------------------------------------------------------
    // APB configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_THRESHOLD:   prdata = PDATA_W'(threshold_reg);
            REG_FRAME_WIDTH: prdata = PDATA_W'(frame_width_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            frame_width_reg <= FWIDTH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_THRESHOLD:   threshold_reg   <= pwdata[PIXEL_W-1:0];
                REG_FRAME_WIDTH: frame_width_reg <= pwdata[FWIDTH_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes: the held pixel is processed unless it ends a frame and
    // the result register is occupied and not being taken.
    // ------------------------------------------------------------------
    assign proc      = pix_valid_reg && (!last_reg || !res_valid_reg || res.ready);
    assign pix.ready = !pix_valid_reg || proc;

    // ------------------------------------------------------------------
    // Recurrence
    // ------------------------------------------------------------------
    always_comb
    begin
        marked = pixel_reg > threshold_reg;
        up     = (row_reg != '0) ? up_reg : '0;
        diag   = (row_reg != '0 && col_reg != '0) ? diag_reg : '0;
        left   = (col_reg != '0) ? left_reg : '0;
        min_lu = (up < left) ? up : left;
        min3   = (diag < min_lu) ? diag : min_lu;
        if (!marked)
            size = '0;
        else if (min3 == SIZE_MAX)
            size = SIZE_MAX;
        else
            size = min3 + size_t'(1);

        if (size >= best_size_reg)
        begin
            best_size_next = size;
            best_row_next  = row_reg;
            best_col_next  = col_reg;
        end
        else
        begin
            best_size_next = best_size_reg;
            best_row_next  = best_row_reg;
            best_col_next  = best_col_reg;
        end

        // Effective row length: zero acts as one, and it is capped at the
        // line buffer depth.
        fw_ext = WW'(frame_width_reg);
        max_w  = WW'(MAX_WIDTH);
        if (frame_width_reg == '0)
            width_eff = WW'(1);
        else if (fw_ext > max_w)
            width_eff = max_w;
        else
            width_eff = fw_ext;
        wrap = (WW'(col_reg) + WW'(1)) >= width_eff;

        if (last_reg)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (wrap)
        begin
            col_next = '0;
            row_next = (row_reg < RW'(MAX_HEIGHT - 1)) ? row_reg + RW'(1) : row_reg;
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end

        col_ext = CXW'(best_col_next);
        row_ext = RXW'(best_row_next);
    end

    // ------------------------------------------------------------------
    // Line buffer: written at the current column, read one pixel ahead so
    // that the up value is registered in time. A one-pixel row reads back
    // the entry it has just written, which the bypass covers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            row_sizes[col_reg] <= size;
            if (col_next == col_reg)
                up_reg <= size;
            else
                up_reg <= row_sizes[col_next];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline and frame state
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            pixel_reg <= pix.pixel;
            last_reg  <= pix.last_of_frame;
        end
        if (proc && last_reg)
        begin
            res_size_reg <= best_size_next;
            res_row_reg  <= row_ext[END_W-1:0];
            res_col_reg  <= col_ext[END_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else
        begin
            if (pix.ready)
                pix_valid_reg <= pix.valid;

            if (proc && last_reg)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            if (proc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (last_reg)
                begin
                    left_reg      <= '0;
                    diag_reg      <= '0;
                    best_size_reg <= '0;
                    best_row_reg  <= '0;
                    best_col_reg  <= '0;
                end
                else
                begin
                    left_reg      <= size;
                    diag_reg      <= up;
                    best_size_reg <= best_size_next;
                    best_row_reg  <= best_row_next;
                    best_col_reg  <= best_col_next;
                end
            end
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.square_size = res_size_reg;
    assign res.end_row     = res_row_reg;
    assign res.end_col     = res_col_reg;

endmodule

`default_nettype wire

// ===== test/square_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_check_pkg
// Predicts the largest marked square of each frame and checks the results.
// ----------------------------------------------------------------------------

package square_check_pkg;

    import lsat_pkg::*;

    typedef struct packed {
        size_t    side;
        end_pos_t row;
        end_pos_t col;
    } square_t;

    class square_scoreboard;

        pixel_t      threshold;
        fwidth_t     frame_width;
        size_t       line_sizes [DEF_MAX_WIDTH];
        size_t       left_side;
        size_t       diag_side;
        int unsigned col_pos;
        int unsigned row_pos;
        square_t     best;
        square_t     expected_squares [$];
        int unsigned mismatch_count;
        int unsigned squares_checked;

        function new();
            threshold       = THRESHOLD_RESET;
            frame_width     = FWIDTH_RESET;
            mismatch_count  = 0;
            squares_checked = 0;
            foreach (line_sizes[i])
                line_sizes[i] = '0;
            restart_frame();
        endfunction

        function void restart_frame();
            left_side = '0;
            diag_side = '0;
            col_pos   = 0;
            row_pos   = 0;
            best      = '0;
        endfunction

        function void write_register(logic index, logic [PDATA_W-1:0] value);
            if (index == REG_THRESHOLD)
                threshold = value[PIXEL_W-1:0];
            else
                frame_width = value[FWIDTH_W-1:0];
        endfunction

        // A width of zero behaves as one, anything past the line buffer as its size.
        function int unsigned width_in_use();
            if (frame_width == 0)
                return 1;
            if (frame_width > DEF_MAX_WIDTH)
                return DEF_MAX_WIDTH;
            return frame_width;
        endfunction

        function void note_pixel(pixel_t value, logic end_of_frame);
            size_t up_side;
            size_t corner;
            size_t left;
            size_t side;
            size_t lowest;
            up_side = '0;
            corner  = '0;
            left    = '0;
            side    = '0;
            if (row_pos > 0)
            begin
                up_side = line_sizes[col_pos];
                if (col_pos > 0)
                    corner = diag_side;
            end
            if (col_pos > 0)
                left = left_side;
            if (value > threshold)
            begin
                lowest = left;
                if (up_side < lowest)
                    lowest = up_side;
                if (corner < lowest)
                    lowest = corner;
                side = (lowest >= SIZE_MAX) ? SIZE_MAX : lowest + 1'b1;
            end
            diag_side           = up_side;
            left_side           = side;
            line_sizes[col_pos] = side;
            if (side >= best.side)
            begin
                best.side = side;
                best.row  = end_pos_t'(row_pos);
                best.col  = end_pos_t'(col_pos);
            end
            if (end_of_frame)
            begin
                expected_squares.push_back(best);
                restart_frame();
            end
            else if (col_pos + 1 >= width_in_use())
            begin
                col_pos = 0;
                if (row_pos < DEF_MAX_HEIGHT - 1)
                    row_pos++;
            end
            else
                col_pos++;
        endfunction

        function void flag(string why, square_t want, square_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] %s: expected side %0d row %0d col %0d, got side %0d row %0d col %0d",
                         $time, why, want.side, want.row, want.col, got.side, got.row, got.col);
        endfunction

        function void check_result(square_t got);
            square_t want;
            squares_checked++;
            if (expected_squares.size() == 0)
                flag("result with no frame pending", '0, got);
            else
            begin
                want = expected_squares.pop_front();
                if (got.side !== want.side || got.row !== want.row || got.col !== want.col)
                    flag("result mismatch", want, got);
            end
        endfunction

    endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the largest marked square unit against a cycle-free predictor.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order and every accepted transfer is fed to
// the scoreboard, which keeps its own line buffer and best-square tracking
// and queues one expected result per end-of-frame pixel. Results are compared
// field by field as they are taken. A short directed part covers the corner
// cases; the random part then works through many register settings under
// four idling patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;

    import lsat_pkg::*;
    import square_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned PIXEL_TARGET   = 550;
    localparam int unsigned SETTING_PIXELS = 46;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TALL_ROWS      = 70;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lsat_pixel_if  pix_bus ();
    lsat_result_if res_bus ();

    square_scoreboard squares = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned pixels_sent;
    int unsigned cycle_count;
    bit          hold_request;

    largest_square_above_threshold_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_bus),
        .res     (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Offers one pixel, idling first at the current rate, and returns once the
    // transfer has happened. valid is left high so that a following pixel can
    // go out back to back.
    task automatic send_pixel(input pixel_t value, input logic end_of_frame);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_bus.valid         <= 1'b1;
        pix_bus.pixel         <= value;
        pix_bus.last_of_frame <= end_of_frame;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        squares.note_pixel(value, end_of_frame);
        pixels_sent++;
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // that closes the access phase. The bus then idles before it is used again.
    task automatic write_reg(input logic index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        squares.write_register(index, value);
        @(posedge clk);
    endtask

    task automatic set_config(input pixel_t thr, input fwidth_t width);
        write_reg(REG_THRESHOLD, PDATA_W'(thr));
        write_reg(REG_FRAME_WIDTH, PDATA_W'(width));
    endtask

    // The block is idle once the last frame's result has been taken; the
    // SETTLE_CYCLES wait then covers the pipeline before the registers are touched.
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (squares.expected_squares.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic pixel_t marked_pixel(pixel_t thr);
        if (thr == 8'hFF)
            return 8'hFF;
        return pixel_t'($urandom_range(255, int'(thr) + 1));
    endfunction

    function automatic pixel_t unmarked_pixel(pixel_t thr);
        return pixel_t'($urandom_range(int'(thr), 0));
    endfunction

    // A frame of whole rows, sometimes cut short mid-row. Most pixels follow a
    // per-frame density so that squares grow; a tenth are plain noise.
    task automatic send_frame(input int unsigned width_used);
        int unsigned rows;
        int unsigned count;
        int unsigned density;
        int unsigned k;
        pixel_t      value;
        rows  = (width_used > 16) ? $urandom_range(2, 1) : $urandom_range(8, 1);
        count = width_used * rows;
        if ($urandom_range(3) == 0)
            count = $urandom_range(count, 1);
        density = ($urandom_range(4) == 0) ? $urandom_range(100) : $urandom_range(100, 60);
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(9) == 0)
                value = pixel_t'($urandom);
            else if ($urandom_range(99) < density)
                value = marked_pixel(squares.threshold);
            else
                value = unmarked_pixel(squares.threshold);
            send_pixel(value, k == count - 1);
        end
    endtask

    // Threshold and width both change at every setting, with the extremes and
    // out-of-range widths drawn now and then; narrow frames dominate.
    task automatic random_config();
        pixel_t  thr;
        fwidth_t width;
        case ($urandom_range(5))
            0:       thr = 8'd0;
            1:       thr = 8'hFF;
            default: thr = pixel_t'($urandom);
        endcase
        case ($urandom_range(9))
            0:       width = 7'd0;
            1:       width = 7'd64;
            2:       width = 7'h7F;
            3:       width = fwidth_t'($urandom_range(127, 1));
            default: width = fwidth_t'($urandom_range(8, 1));
        endcase
        set_config(thr, width);
    endtask

    // Result side: takes each transfer, then chooses ready for the next cycle.
    // A hold-off request keeps ready low for a long stretch so that a second
    // end-of-frame pixel is held at the input.
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                squares.check_result(square_t'{res_bus.square_size, res_bus.end_row,
                                               res_bus.end_col});
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned setting;
        int unsigned mode;
        int unsigned start;
        int unsigned k;
        int unsigned j;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        pix_bus.valid         <= 1'b0;
        pix_bus.pixel         <= '0;
        pix_bus.last_of_frame <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        pixels_sent    = 0;
        rst_n <= 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, one-pixel frames: just above the threshold, exactly
        // on it (unmarked), and the two extremes of the pixel range.
        send_pixel(8'd51, 1'b1);
        send_pixel(8'd50, 1'b1);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'hFF, 1'b1);

        // A full 2x2 square, then an L shape where the later tie must win.
        wait_idle();
        set_config(8'd0, 7'd2);
        repeat (3)
            send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd1, 1'b1);

        // Nothing can exceed 255, so an empty frame reports its last pixel;
        // a zero width behaves as a single column.
        wait_idle();
        set_config(8'hFF, 7'd0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b1);

        // A width beyond the line buffer, then a frame ended mid-row.
        wait_idle();
        set_config(8'd254, 7'h7F);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'd254, 1'b1);
        wait_idle();
        set_config(8'd100, 7'd3);
        repeat (4)
            send_pixel(8'd200, 1'b0);
        send_pixel(8'd200, 1'b1);

        // Random settings, three per idling pattern, until enough pixels have
        // gone through.
        setting     = 0;
        pixels_sent = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            wait_idle();
            mode = (setting / 3) % 4;
            case (mode)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (setting == 0)
            begin
                // One column, more rows than the row counter holds, so the row
                // index has to saturate.
                set_config(8'd0, 7'd1);
                for (k = 0; k < TALL_ROWS; k++)
                    send_pixel(8'hFF, k == TALL_ROWS - 1);
            end
            else
            begin
                random_config();
                if (setting == 1)
                begin
                    // Receiver held off while short frames keep coming, so the
                    // result register fills and the input stalls; afterwards
                    // the sender waits until every result has been taken.
                    hold_request = 1'b1;
                    for (j = 0; j < 8; j++)
                    begin
                        k = $urandom_range(3, 1);
                        while (k > 0)
                        begin
                            k--;
                            send_pixel(pixel_t'($urandom), k == 0);
                        end
                    end
                    wait_idle();
                end
                start = pixels_sent;
                while (pixels_sent - start < SETTING_PIXELS)
                    send_frame(squares.width_in_use());
            end
            setting++;
        end

        wait_idle();
        if (squares.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== largest_square_above_threshold_unit.f =====
src/lsat_pkg.sv
src/lsat_if.sv
src/largest_square_above_threshold_unit.sv
test/square_check_pkg.sv
test/testbench.sv
